[design/cas_pkg.sv]
// Shared types and constants for the call argument splitter.
`default_nettype none

package cas_pkg;

  // Default bracket stack depth
  localparam int STACK_DEPTH_DEF = 16;

  typedef logic [7:0] char_t;

  // Characters the parser reacts to
  localparam char_t CHR_LPAREN = 8'h28;  // (
  localparam char_t CHR_RPAREN = 8'h29;  // )
  localparam char_t CHR_LCURLY = 8'h7B;  // {
  localparam char_t CHR_RCURLY = 8'h7D;  // }
  localparam char_t CHR_SEMI   = 8'h3B;  // ;
  localparam char_t CHR_DQUOTE = 8'h22;  // "
  localparam char_t CHR_SQUOTE = 8'h27;  // '
  localparam char_t CHR_SPACE  = 8'h20;
  localparam char_t CHR_COMMA  = 8'h2C;
  localparam char_t CHR_BSLASH = 8'h5C;

  // Stack commands from the parser (push, pop and clear already gated by the step enable)
  typedef struct packed {
    logic push;
    logic pop;
    logic curly;   // bracket kind: 1 = curly, 0 = round
    logic clear;   // end of list, back to empty
  } stk_ctrl_t;

  // Stack status seen by the parser
  typedef struct packed {
    logic empty;
    logic single;  // exactly one entry
    logic full;
    logic tos;     // kind of the top entry, valid when not empty
  } stk_stat_t;

  // One result item
  typedef struct packed {
    char_t out_char;
    logic  keep;
    logic  arg_end;
    logic  error;
  } res_t;

endpackage

`default_nettype wire

[design/cas_if.sv]
// Valid/ready channel interfaces for the splitter input and result streams.
`default_nettype none

interface cas_in_if;
  logic          valid;
  logic          ready;
  cas_pkg::char_t ch;
  logic          last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface cas_out_if;
  logic          valid;
  logic          ready;
  cas_pkg::char_t out_char;
  logic          keep;
  logic          arg_end;
  logic          error;

  modport source (output valid, output out_char, output keep, output arg_end,
                  output error, input ready);
  modport sink   (input valid, input out_char, input keep, input arg_end,
                  input error, output ready);
endinterface

`default_nettype wire

[design/cas_stack.sv]
// Bracket kind stack: level counter, memory, cached top and next-below entries.
`default_nettype none

module cas_stack #(
  parameter int STACK_DEPTH = cas_pkg::STACK_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  cas_pkg::stk_ctrl_t  ctrl,
  output cas_pkg::stk_stat_t  stat
);
  import cas_pkg::*;

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [LW-1:0] level_r, level_nxt;
  logic          tos_r, tos_nxt;
  logic          nos_r;            // entry just below the top
  logic          mem [STACK_DEPTH];
  logic          push_ok, pop_ok;
  logic [LW-1:0] rd_lvl;
  logic [AW-1:0] rd_addr;

  // Pushes beyond full and pops on empty are dropped
  assign push_ok = ctrl.push && (level_r != LW'(STACK_DEPTH));
  assign pop_ok  = ctrl.pop && (level_r != '0);

  // Next level and cached top
  always_comb begin
    level_nxt = level_r;
    tos_nxt   = tos_r;
    if (ctrl.clear) begin
      level_nxt = '0;
    end else if (push_ok) begin
      level_nxt = level_r + LW'(1);
      tos_nxt   = ctrl.curly;
    end else if (pop_ok) begin
      level_nxt = level_r - LW'(1);
      tos_nxt   = nos_r;
    end
  end

  // Read the entry that will sit below the top next cycle
  assign rd_lvl  = level_nxt - LW'(2);
  assign rd_addr = rd_lvl[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  // Memory write and registered read; the read never hits the write address
  always_ff @(posedge clk) begin
    if (push_ok && !ctrl.clear) begin
      mem[level_r[AW-1:0]] <= ctrl.curly;
    end
    nos_r <= mem[rd_addr];
    tos_r <= tos_nxt;
  end

  assign stat.empty  = (level_r == '0);
  assign stat.single = (level_r == LW'(1));
  assign stat.full   = (level_r == LW'(STACK_DEPTH));
  assign stat.tos    = tos_r;

  // Level never passes the depth
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(STACK_DEPTH))
    else $error("stack level above depth");

  // Parser never pushes and pops at once
  a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.push && ctrl.pop))
    else $error("push and pop together");

  // A pop on a non-empty stack takes exactly one entry off
  a_pop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.pop && !stat.empty && !ctrl.clear) |=> (level_r == $past(level_r) - LW'(1)))
    else $error("pop did not decrement level");

endmodule

`default_nettype wire

[design/cas_parse.sv]
// Character classifier, literal/escape flags, error flag and result build.
`default_nettype none

module cas_parse (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step,
  input  cas_pkg::char_t      ch,
  input  wire                 last,
  input  cas_pkg::stk_stat_t  stat,
  output cas_pkg::stk_ctrl_t  ctrl,
  output cas_pkg::res_t       res
);
  import cas_pkg::*;

  logic in_string_r, in_string_nxt;
  logic in_char_r,   in_char_nxt;
  logic escaped_r,   escaped_nxt;
  logic first_r,     first_nxt;
  logic failed_r,    failed_nxt;

  logic quoted, top_before, keep;
  logic is_open, is_close, fail_now, level_zero_after, arg_end;

  assign quoted     = in_string_r || in_char_r;
  assign top_before = stat.empty && !quoted;
  assign is_open    = !quoted && ((ch == CHR_LPAREN) || (ch == CHR_LCURLY));
  assign is_close   = !quoted && ((ch == CHR_RPAREN) || (ch == CHR_RCURLY));

  // Keep decision outside literals
  always_comb begin
    keep = 1'b1;
    if (!quoted) begin
      case (ch)
        CHR_SEMI, CHR_COMMA: keep = !stat.empty;
        CHR_SPACE:           keep = 1'b0;
        default:             keep = 1'b1;
      endcase
    end
  end

  // Literal and escape flags
  always_comb begin
    in_string_nxt = in_string_r;
    in_char_nxt   = in_char_r;
    escaped_nxt   = escaped_r;
    if (!quoted) begin
      if (ch == CHR_DQUOTE) in_string_nxt = 1'b1;
      if (ch == CHR_SQUOTE) in_char_nxt   = 1'b1;
    end else if (escaped_r) begin
      escaped_nxt = 1'b0;
    end else if (ch == CHR_DQUOTE) begin
      in_string_nxt = 1'b0;
    end else if (ch == CHR_SQUOTE) begin
      in_char_nxt = 1'b0;
    end else if (ch == CHR_BSLASH) begin
      escaped_nxt = 1'b1;
    end
  end

  // Bracket faults: overflow, closer on empty, closer of the wrong kind
  assign fail_now = (is_open && stat.full)
                 || (is_close && stat.empty)
                 || (is_close && !stat.empty && (stat.tos != (ch == CHR_RCURLY)));

  assign level_zero_after = (stat.empty && !(is_open && !stat.full))
                         || (stat.single && is_close);

  assign failed_nxt = failed_r || fail_now || (last && !level_zero_after);

  assign arg_end = ((ch == CHR_COMMA) && top_before && !first_r)
                || (last && level_zero_after && !in_string_nxt && !in_char_nxt);

  assign first_nxt = last;

  // Stack commands, only on a real step
  assign ctrl.push  = step && is_open;
  assign ctrl.pop   = step && is_close;
  assign ctrl.curly = (ch == CHR_LCURLY) || (ch == CHR_RCURLY);
  assign ctrl.clear = step && last;

  assign res.out_char = keep ? ch : '0;
  assign res.keep     = keep;
  assign res.arg_end  = arg_end;
  assign res.error    = failed_nxt;

  // Flag state; end of list returns everything to reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_string_r <= 1'b0;
      in_char_r   <= 1'b0;
      escaped_r   <= 1'b0;
      first_r     <= 1'b1;
      failed_r    <= 1'b0;
    end else if (step) begin
      if (last) begin
        in_string_r <= 1'b0;
        in_char_r   <= 1'b0;
        escaped_r   <= 1'b0;
        failed_r    <= 1'b0;
      end else begin
        in_string_r <= in_string_nxt;
        in_char_r   <= in_char_nxt;
        escaped_r   <= escaped_nxt;
        failed_r    <= failed_nxt;
      end
      first_r <= first_nxt;
    end
  end

  // Every list end leaves a clean state
  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last) |=> (first_r && !failed_r && !in_string_r && !in_char_r && !escaped_r))
    else $error("state not cleared at end of list");

  // String and char literal modes exclude each other
  a_one_literal: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_string_r && in_char_r))
    else $error("string and char literal both open");

  // Escape only pending inside a literal
  a_escape_scope: assert property (@(posedge clk) disable iff (!rst_n)
    escaped_r |-> (in_string_r || in_char_r))
    else $error("escape pending outside a literal");

endmodule

`default_nettype wire

[design/call_argument_splitter.sv]
// Top level of the call argument splitter: input register, parser, stack, result register.
//
//  channel   dir   handshake       payload
//  in_chan   in    valid / ready   ch[7:0], last
//  out_chan  out   valid / ready   out_char[7:0], keep, arg_end, error
//
// One character per cycle sustained while the output is not stalled; a result
// passes through the input register and then the result register before it is
// offered.
// All per-character work is one pass of the parser and stack from the input
// register into the result register; the top-of-stack entry is cached so the
// bracket memory needs only one registered read per cycle.
// Reset (rst_n low, synchronous) empties the pipeline and clears all flags.
// A stalled result holds in the result register while one more character
// waits in the input register.
`default_nettype none

module call_argument_splitter #(
  parameter int STACK_DEPTH = cas_pkg::STACK_DEPTH_DEF
) (
  input  wire       clk,
  input  wire       rst_n,
  cas_in_if.sink    in_chan,
  cas_out_if.source out_chan
);
  import cas_pkg::*;

  logic      in_vld_r;
  char_t     ch_r;
  logic      last_r;
  logic      out_vld_r;
  res_t      res_r;
  res_t      res;
  logic      advance;
  logic      in_rdy;
  stk_ctrl_t stk_ctrl;
  stk_stat_t stk_stat;

  // Pipeline flow
  assign advance = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_rdy  = !in_vld_r || advance;
  assign in_chan.ready = in_rdy;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_rdy) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_chan.valid) begin
      ch_r   <= in_chan.ch;
      last_r <= in_chan.last;
    end
  end

  cas_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .ch    (ch_r),
    .last  (last_r),
    .stat  (stk_stat),
    .ctrl  (stk_ctrl),
    .res   (res)
  );

  cas_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (stk_ctrl),
    .stat  (stk_stat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_chan.valid    = out_vld_r;
  assign out_chan.out_char = res_r.out_char;
  assign out_chan.keep     = res_r.keep;
  assign out_chan.arg_end  = res_r.arg_end;
  assign out_chan.error    = res_r.error;

endmodule

`default_nettype wire
